/* hw/rtl/vgss_pkg.sv */
package vgss_pkg;

    // opcodes
    localparam logic [2:0] OP_PUT_VOX = 3'd0;
    localparam logic [2:0] OP_CUT_VOX = 3'd1;
    localparam logic [2:0] OP_PUT_BOX = 3'd2;
    localparam logic [2:0] OP_CUT_BOX = 3'd3;
    localparam logic [2:0] OP_PUT_ELL = 3'd4;
    localparam logic [2:0] OP_CUT_ELL = 3'd5;
    localparam logic [2:0] OP_READ    = 3'd6;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CLIP     = 2'd1;
    localparam logic [1:0] ST_ZERO_RAD = 2'd2;

    // config register indexes
    localparam int         CFG_IDX_W  = 2;
    localparam logic [1:0] CFG_RED    = 2'd0;
    localparam logic [1:0] CFG_GREEN  = 2'd1;
    localparam logic [1:0] CFG_BLUE   = 2'd2;
    localparam logic [1:0] CFG_ALPHA  = 2'd3;

    // shared multiplier widths
    localparam int MUL_A_W = 16;
    localparam int MUL_B_W = 28;
    localparam int PROD_W  = 44;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_rgba;

endpackage

/* hw/rtl/vgss_in_if.sv */
interface vgss_in_if;
    logic              valid;
    logic              ready;
    logic [2:0]        opcode;
    logic signed [7:0] first_x;
    logic signed [7:0] first_y;
    logic signed [7:0] first_z;
    logic [6:0]        second_x;
    logic [6:0]        second_y;
    logic [6:0]        second_z;

    modport source (output valid, opcode, first_x, first_y, first_z,
                    second_x, second_y, second_z, input ready);
    modport sink   (input valid, opcode, first_x, first_y, first_z,
                    second_x, second_y, second_z, output ready);
endinterface

/* hw/rtl/vgss_out_if.sv */
interface vgss_out_if;
    logic        valid;
    logic        ready;
    logic        voxel_on;
    logic [7:0]  voxel_red;
    logic [7:0]  voxel_green;
    logic [7:0]  voxel_blue;
    logic [7:0]  voxel_alpha;
    logic [15:0] filled_count;
    logic [1:0]  status;

    modport source (output valid, voxel_on, voxel_red, voxel_green, voxel_blue,
                    voxel_alpha, filled_count, status, input ready);
    modport sink   (input valid, voxel_on, voxel_red, voxel_green, voxel_blue,
                    voxel_alpha, filled_count, status, output ready);
endinterface

/* hw/rtl/voxel_grid_shape_sculptor_core.sv */
// Voxel op: a read step and a write step on the cell, result registered; box: a
// read step and a write step per voxel in the box. Ellipsoid: setup steps, a row
// step per (x,y) row, a read step and a write step per voxel of the grid; one
// shared multiplier and the grid RAM port set the pace. One item in flight; a
// finished result waits in the output register. After reset a clearing pass over
// all GRID_X*GRID_Y*GRID_Z cells clears occupancy; no item is taken meanwhile, config writes are.
module voxel_grid_shape_sculptor_core #(
    parameter int GRID_X = 32,
    parameter int GRID_Y = 32,
    parameter int GRID_Z = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    vgss_in_if.sink                        i_in,
    vgss_out_if.source                     o_out,
    input  logic                           i_cfg_we,
    input  logic [vgss_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                     i_cfg_data
);
    localparam int CELLS = GRID_X * GRID_Y * GRID_Z;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CW    = $clog2(CELLS + 1);

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SETUP = 3'd2;
    localparam logic [2:0] S_ROW   = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_WR    = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0]        r_state;
    logic [3:0]        r_step;
    logic [AW-1:0]     r_clr_addr;
    logic [CW-1:0]     r_cnt;
    vgss_pkg::t_rgba   r_paint;

    logic [2:0]        r_op;
    logic signed [7:0] r_fx, r_fy, r_fz;
    logic [6:0]        r_sx, r_sy, r_sz;
    logic [6:0]        r_i, r_j, r_k;
    logic [6:0]        r_lo_y, r_lo_z, r_hi_x, r_hi_y, r_hi_z;
    logic [1:0]        r_status;
    logic              r_on;
    vgss_pkg::t_rgba   r_col;

    logic [13:0]       r_ax, r_ay, r_az;
    logic [27:0]       r_wx, r_wy, r_wz;
    logic [41:0]       r_lim;
    logic [15:0]       r_sqz0, r_sq;
    logic signed [9:0] r_dz;
    logic [43:0]       r_px;
    logic [44:0]       r_pxy;

    logic              r_out_valid;
    logic              r_out_on;
    vgss_pkg::t_rgba   r_out_col;
    logic [15:0]       r_out_cnt;
    logic [1:0]        r_out_status;

    // shared multiplier
    logic [vgss_pkg::MUL_A_W-1:0] w_ma;
    logic [vgss_pkg::MUL_B_W-1:0] w_mb;
    logic [vgss_pkg::PROD_W-1:0]  r_prod;

    // grid memory
    logic              w_we, w_wocc, w_wcol_en, w_rocc;
    logic [AW-1:0]     w_addr, w_waddr;
    vgss_pkg::t_rgba   w_rcol;

    logic              w_ell, w_put, w_read, w_sel, w_out_free;
    logic signed [9:0] w_dx, w_dy;
    logic [7:0]        w_tx, w_ty, w_tfz;
    logic signed [8:0] w_fz9;
    logic signed [17:0] w_sq_nx;
    logic [45:0]       w_sum;

    // accept-time decode
    logic              w_in_grid, w_zero_rad, w_ctr_out, w_box_clip, w_box_empty;
    logic [6:0]        w_x0, w_y0, w_z0, w_x1, w_y1, w_z1;

    assign w_ell  = (r_op == vgss_pkg::OP_PUT_ELL) || (r_op == vgss_pkg::OP_CUT_ELL);
    assign w_put  = (r_op == vgss_pkg::OP_PUT_VOX) || (r_op == vgss_pkg::OP_PUT_BOX) ||
                    (r_op == vgss_pkg::OP_PUT_ELL);
    assign w_read = (r_op == vgss_pkg::OP_READ);

    assign w_addr = AW'((int'(r_i) * GRID_Y + int'(r_j)) * GRID_Z + int'(r_k));

    assign w_dx  = $signed({2'b00, r_i, 1'b0}) - 10'(r_fx);
    assign w_dy  = $signed({2'b00, r_j, 1'b0}) - 10'(r_fy);
    assign w_tx  = w_dx[9] ? 8'(-w_dx) : w_dx[7:0];
    assign w_ty  = w_dy[9] ? 8'(-w_dy) : w_dy[7:0];
    assign w_fz9 = 9'(r_fz);
    assign w_tfz = w_fz9[8] ? 8'(-w_fz9) : w_fz9[7:0];

    // (dz+2)^2 = dz^2 + 4dz + 4
    assign w_sq_nx = $signed({2'b00, r_sq}) + ($signed(18'(r_dz)) <<< 2) + 18'sd4;

    assign w_sum = 46'(r_pxy) + 46'(r_prod);
    assign w_sel = w_ell ? (w_sum <= 46'(r_lim)) : 1'b1;

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_SETUP: begin
                unique case (r_step)
                    4'd0:    begin w_ma = 16'(r_sx);   w_mb = 28'(r_sx); end
                    4'd1:    begin w_ma = 16'(r_sy);   w_mb = 28'(r_sy); end
                    4'd2:    begin w_ma = 16'(r_sz);   w_mb = 28'(r_sz); end
                    4'd4:    begin w_ma = 16'(r_ay);   w_mb = 28'(r_az); end
                    4'd5:    begin w_ma = 16'(r_ax);   w_mb = 28'(r_az); end
                    4'd6:    begin w_ma = 16'(r_ax);   w_mb = 28'(r_ay); end
                    4'd8:    begin w_ma = 16'(r_az);   w_mb = r_wz;      end
                    4'd10:   begin w_ma = 16'(w_tfz);  w_mb = 28'(w_tfz); end
                    default: ;
                endcase
            end
            S_ROW: begin
                unique case (r_step)
                    4'd0:    begin w_ma = 16'(w_tx);       w_mb = 28'(w_tx); end
                    4'd1:    begin w_ma = r_prod[15:0];    w_mb = r_wx;      end
                    4'd2:    begin w_ma = 16'(w_ty);       w_mb = 28'(w_ty); end
                    4'd3:    begin w_ma = r_prod[15:0];    w_mb = r_wy;      end
                    default: ;
                endcase
            end
            S_RD: begin
                w_ma = r_sq;
                w_mb = r_wz;
            end
            default: ;
        endcase
    end

    vgss_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (r_prod)
    );

    assign w_we      = (r_state == S_CLR) || ((r_state == S_WR) && w_sel && !w_read);
    assign w_waddr   = (r_state == S_CLR) ? r_clr_addr : w_addr;
    assign w_wocc    = (r_state == S_WR) && w_put;
    assign w_wcol_en = (r_state == S_WR) && w_put;

    vgss_grid_mem #(
        .CELLS (CELLS),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wocc    (w_wocc),
        .i_wcol_en (w_wcol_en),
        .i_wcol    (r_paint),
        .i_raddr   (w_addr),
        .o_rocc    (w_rocc),
        .o_rcol    (w_rcol)
    );

    always_comb begin
        w_in_grid = !i_in.first_x[7] && (int'(i_in.first_x) < GRID_X) &&
                    !i_in.first_y[7] && (int'(i_in.first_y) < GRID_Y) &&
                    !i_in.first_z[7] && (int'(i_in.first_z) < GRID_Z);
        w_x0 = i_in.first_x[7] ? 7'd0 : i_in.first_x[6:0];
        w_y0 = i_in.first_y[7] ? 7'd0 : i_in.first_y[6:0];
        w_z0 = i_in.first_z[7] ? 7'd0 : i_in.first_z[6:0];
        w_x1 = (int'(i_in.second_x) > GRID_X) ? 7'(GRID_X) : i_in.second_x;
        w_y1 = (int'(i_in.second_y) > GRID_Y) ? 7'(GRID_Y) : i_in.second_y;
        w_z1 = (int'(i_in.second_z) > GRID_Z) ? 7'(GRID_Z) : i_in.second_z;
        w_box_clip = i_in.first_x[7] || i_in.first_y[7] || i_in.first_z[7] ||
                     (int'(i_in.second_x) > GRID_X) || (int'(i_in.second_y) > GRID_Y) ||
                     (int'(i_in.second_z) > GRID_Z);
        w_box_empty = (w_x0 >= w_x1) || (w_y0 >= w_y1) || (w_z0 >= w_z1);
        w_zero_rad = (i_in.second_x == 7'd0) || (i_in.second_y == 7'd0) ||
                     (i_in.second_z == 7'd0);
        w_ctr_out = i_in.first_x[7] || (int'(i_in.first_x) > 2 * (GRID_X - 1)) ||
                    i_in.first_y[7] || (int'(i_in.first_y) > 2 * (GRID_Y - 1)) ||
                    i_in.first_z[7] || (int'(i_in.first_z) > 2 * (GRID_Z - 1));
    end

    assign w_out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_step      <= '0;
            r_clr_addr  <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_paint     <= '{alpha: 8'd255, blue: 8'd0, green: 8'd0, red: 8'd0};
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    vgss_pkg::CFG_RED:   r_paint.red   <= i_cfg_data;
                    vgss_pkg::CFG_GREEN: r_paint.green <= i_cfg_data;
                    vgss_pkg::CFG_BLUE:  r_paint.blue  <= i_cfg_data;
                    vgss_pkg::CFG_ALPHA: r_paint.alpha <= i_cfg_data;
                    default: ;
                endcase
            end

            if ((r_state == S_FIN) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(CELLS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_op   <= i_in.opcode;
                        r_fx   <= i_in.first_x;
                        r_fy   <= i_in.first_y;
                        r_fz   <= i_in.first_z;
                        r_sx   <= i_in.second_x;
                        r_sy   <= i_in.second_y;
                        r_sz   <= i_in.second_z;
                        r_on   <= 1'b0;
                        r_col  <= '0;
                        r_step <= '0;
                        unique case (i_in.opcode)
                            vgss_pkg::OP_PUT_VOX, vgss_pkg::OP_CUT_VOX,
                            vgss_pkg::OP_READ: begin
                                r_i <= i_in.first_x[6:0];
                                r_j <= i_in.first_y[6:0];
                                r_k <= i_in.first_z[6:0];
                                r_lo_y <= i_in.first_y[6:0];
                                r_lo_z <= i_in.first_z[6:0];
                                r_hi_x <= i_in.first_x[6:0] + 7'd1;
                                r_hi_y <= i_in.first_y[6:0] + 7'd1;
                                r_hi_z <= i_in.first_z[6:0] + 7'd1;
                                r_status <= w_in_grid ? vgss_pkg::ST_OK : vgss_pkg::ST_CLIP;
                                r_state  <= w_in_grid ? S_RD : S_FIN;
                            end
                            vgss_pkg::OP_PUT_BOX, vgss_pkg::OP_CUT_BOX: begin
                                r_i <= w_x0;
                                r_j <= w_y0;
                                r_k <= w_z0;
                                r_lo_y <= w_y0;
                                r_lo_z <= w_z0;
                                r_hi_x <= w_x1;
                                r_hi_y <= w_y1;
                                r_hi_z <= w_z1;
                                r_status <= w_box_clip ? vgss_pkg::ST_CLIP : vgss_pkg::ST_OK;
                                r_state  <= w_box_empty ? S_FIN : S_RD;
                            end
                            vgss_pkg::OP_PUT_ELL, vgss_pkg::OP_CUT_ELL: begin
                                r_i <= '0;
                                r_j <= '0;
                                r_k <= '0;
                                r_lo_y <= '0;
                                r_lo_z <= '0;
                                r_hi_x <= 7'(GRID_X);
                                r_hi_y <= 7'(GRID_Y);
                                r_hi_z <= 7'(GRID_Z);
                                if (w_zero_rad) begin
                                    r_status <= vgss_pkg::ST_ZERO_RAD;
                                    r_state  <= S_FIN;
                                end else begin
                                    r_status <= w_ctr_out ? vgss_pkg::ST_CLIP
                                                          : vgss_pkg::ST_OK;
                                    r_state  <= S_SETUP;
                                end
                            end
                            default: begin
                                r_status <= vgss_pkg::ST_OK;
                                r_state  <= S_FIN;
                            end
                        endcase
                    end
                end
                S_SETUP: begin
                    // radius squares, pairwise weights, limit, then (fz)^2 for k = 0
                    if (r_step == 4'd11) begin
                        r_sqz0  <= r_prod[15:0];
                        r_step  <= '0;
                        r_state <= S_ROW;
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                    unique case (r_step)
                        4'd1:    r_ax   <= r_prod[13:0];
                        4'd2:    r_ay   <= r_prod[13:0];
                        4'd3:    r_az   <= r_prod[13:0];
                        4'd5:    r_wx   <= r_prod[27:0];
                        4'd6:    r_wy   <= r_prod[27:0];
                        4'd7:    r_wz   <= r_prod[27:0];
                        4'd9:    r_lim  <= r_prod[41:0];
                        default: ;
                    endcase
                end
                S_ROW: begin
                    if (r_step == 4'd4) begin
                        r_pxy   <= 45'(r_px) + 45'(r_prod);
                        r_sq    <= r_sqz0;
                        r_dz    <= -10'(r_fz);
                        r_step  <= '0;
                        r_state <= S_RD;
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                    if (r_step == 4'd2) begin
                        r_px <= r_prod;
                    end
                end
                S_RD: begin
                    r_state <= S_WR;
                end
                S_WR: begin
                    if (w_read) begin
                        r_on  <= w_rocc;
                        r_col <= w_rocc ? w_rcol : '0;
                    end
                    if (w_we) begin
                        if (w_put && !w_rocc) begin
                            r_cnt <= r_cnt + 1'b1;
                        end else if (!w_put && w_rocc) begin
                            r_cnt <= r_cnt - 1'b1;
                        end
                    end
                    if (8'(r_k) + 8'd1 < 8'(r_hi_z)) begin
                        r_k     <= r_k + 7'd1;
                        r_sq    <= 16'(w_sq_nx);
                        r_dz    <= r_dz + 10'sd2;
                        r_state <= S_RD;
                    end else begin
                        r_k <= r_lo_z;
                        if (8'(r_j) + 8'd1 < 8'(r_hi_y)) begin
                            r_j     <= r_j + 7'd1;
                            r_state <= w_ell ? S_ROW : S_RD;
                        end else begin
                            r_j <= r_lo_y;
                            if (8'(r_i) + 8'd1 < 8'(r_hi_x)) begin
                                r_i     <= r_i + 7'd1;
                                r_state <= w_ell ? S_ROW : S_RD;
                            end else begin
                                r_state <= S_FIN;
                            end
                        end
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output payload, loaded with the result beat
    always_ff @(posedge i_clk) begin
        if ((r_state == S_FIN) && w_out_free) begin
            r_out_on     <= r_on;
            r_out_col    <= r_col;
            r_out_cnt    <= 16'(r_cnt);
            r_out_status <= r_status;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.voxel_on     = r_out_on;
    assign o_out.voxel_red    = r_out_col.red;
    assign o_out.voxel_green  = r_out_col.green;
    assign o_out.voxel_blue   = r_out_col.blue;
    assign o_out.voxel_alpha  = r_out_col.alpha;
    assign o_out.filled_count = r_out_cnt;
    assign o_out.status       = r_out_status;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_cnt) <= CELLS)
        else $error("on count above grid size");

    a_wr_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |-> ($past(r_state) == S_RD))
        else $error("grid write without a preceding read");

    a_we_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> ((r_state == S_WR) || (r_state == S_CLR)))
        else $error("grid write outside sweep or clear");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> r_out_valid)
        else $error("pending result dropped");

endmodule

/* hw/rtl/vgss_mul.sv */
module vgss_mul (
    input  logic                         i_clk,
    input  logic [vgss_pkg::MUL_A_W-1:0] i_a,
    input  logic [vgss_pkg::MUL_B_W-1:0] i_b,
    output logic [vgss_pkg::PROD_W-1:0]  o_p
);
    always_ff @(posedge i_clk) begin
        o_p <= vgss_pkg::PROD_W'(i_a) * vgss_pkg::PROD_W'(i_b);
    end
endmodule

/* hw/rtl/vgss_grid_mem.sv */
module vgss_grid_mem #(
    parameter int CELLS = 32768,
    parameter int AW    = 15
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  logic                  i_wocc,
    input  logic                  i_wcol_en,
    input  vgss_pkg::t_rgba       i_wcol,
    input  logic [AW-1:0]         i_raddr,
    output logic                  o_rocc,
    output vgss_pkg::t_rgba       o_rcol
);
    logic            mem_occ [CELLS];
    vgss_pkg::t_rgba mem_col [CELLS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem_occ[i_waddr] <= i_wocc;
        end
        if (i_we && i_wcol_en) begin
            mem_col[i_waddr] <= i_wcol;
        end
        o_rocc <= mem_occ[i_raddr];
        o_rcol <= mem_col[i_raddr];
    end
endmodule

/* dv/tb_voxel_grid_shape_sculptor_core.sv */
`timescale 1ns / 100ps

module tb_voxel_grid_shape_sculptor_core;

    localparam int GX = 32;
    localparam int GY = 32;
    localparam int GZ = 32;
    localparam int CELLS = GX * GY * GZ;
    localparam int CYCLE_LIMIT = 5000000;
    localparam int LONG_HOLD = 400;
    localparam logic [2:0] OP_UNUSED = 3'd7;

    typedef struct {
        logic [2:0]        op;
        logic signed [7:0] fx, fy, fz;
        logic [6:0]        sx, sy, sz;
    } t_op_item;

    typedef struct {
        logic            on;
        vgss_pkg::t_rgba color;
        logic [15:0]     count;
        logic [1:0]      status;
    } t_voxel_res;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [vgss_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [7:0] i_cfg_data;

    vgss_in_if  in_if ();
    vgss_out_if out_if ();

    voxel_grid_shape_sculptor_core #(.GRID_X(GX), .GRID_Y(GY), .GRID_Z(GZ)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if.sink),
        .o_out      (out_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // shadow grid
    bit              occ_map [CELLS];
    logic [31:0]     color_map [CELLS];
    int unsigned     on_total;
    vgss_pkg::t_rgba paint;

    t_op_item   op_pending [$];
    t_voxel_res res_expected [$];
    t_op_item   cur_op;
    int         fail_cnt;
    int         cycle_cnt;
    int         send_gap;
    int         recv_hold;
    bit         no_idle;
    int         long_req;
    int         long_done;
    int         ell_budget;
    int         wide_box_budget;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 7);
    endfunction

    function automatic int cell_at(int x, int y, int z);
        return (x * GY + y) * GZ + z;
    endfunction

    function automatic void touch_cell(int n, bit put);
        if (put) begin
            if (!occ_map[n]) on_total++;
            occ_map[n] = 1'b1;
            color_map[n] = paint;
        end else begin
            if (occ_map[n]) on_total--;
            occ_map[n] = 1'b0;
        end
    endfunction

    function automatic t_voxel_res sculpt_predict(t_op_item it);
        t_voxel_res r;
        int fx, fy, fz, sx, sy, sz, x0, y0, z0, x1, y1, z1, n, dx, dy, dz;
        bit flag;
        longint unsigned ax, ay, az, wx, wy, wz, lim, px, py, pz;
        fx = it.fx; fy = it.fy; fz = it.fz;
        sx = it.sx; sy = it.sy; sz = it.sz;
        r.on = 1'b0;
        r.color = '0;
        r.status = vgss_pkg::ST_OK;
        case (it.op)
            vgss_pkg::OP_PUT_VOX, vgss_pkg::OP_CUT_VOX, vgss_pkg::OP_READ: begin
                if (fx < 0 || fx >= GX || fy < 0 || fy >= GY || fz < 0 || fz >= GZ) begin
                    r.status = vgss_pkg::ST_CLIP;
                end else begin
                    n = cell_at(fx, fy, fz);
                    if (it.op == vgss_pkg::OP_READ) begin
                        if (occ_map[n]) begin
                            r.on = 1'b1;
                            r.color = color_map[n];
                        end
                    end else begin
                        touch_cell(n, it.op == vgss_pkg::OP_PUT_VOX);
                    end
                end
            end
            vgss_pkg::OP_PUT_BOX, vgss_pkg::OP_CUT_BOX: begin
                flag = 0;
                x0 = fx; y0 = fy; z0 = fz; x1 = sx; y1 = sy; z1 = sz;
                if (x0 < 0) begin x0 = 0; flag = 1; end
                if (y0 < 0) begin y0 = 0; flag = 1; end
                if (z0 < 0) begin z0 = 0; flag = 1; end
                if (x1 > GX) begin x1 = GX; flag = 1; end
                if (y1 > GY) begin y1 = GY; flag = 1; end
                if (z1 > GZ) begin z1 = GZ; flag = 1; end
                for (int i = x0; i < x1; i++)
                    for (int j = y0; j < y1; j++)
                        for (int k = z0; k < z1; k++)
                            touch_cell(cell_at(i, j, k), it.op == vgss_pkg::OP_PUT_BOX);
                if (flag) r.status = vgss_pkg::ST_CLIP;
            end
            vgss_pkg::OP_PUT_ELL, vgss_pkg::OP_CUT_ELL: begin
                if (sx == 0 || sy == 0 || sz == 0) begin
                    r.status = vgss_pkg::ST_ZERO_RAD;
                end else begin
                    ax = sx * sx; ay = sy * sy; az = sz * sz;
                    wx = ay * az; wy = ax * az; wz = ax * ay; lim = ax * ay * az;
                    for (int i = 0; i < GX; i++) begin
                        dx = 2 * i - fx;
                        if (dx < 0) dx = -dx;
                        px = longint'(dx) * dx * wx;
                        for (int j = 0; j < GY; j++) begin
                            dy = 2 * j - fy;
                            if (dy < 0) dy = -dy;
                            py = longint'(dy) * dy * wy;
                            for (int k = 0; k < GZ; k++) begin
                                dz = 2 * k - fz;
                                if (dz < 0) dz = -dz;
                                pz = longint'(dz) * dz * wz;
                                if (px + py + pz <= lim)
                                    touch_cell(cell_at(i, j, k),
                                               it.op == vgss_pkg::OP_PUT_ELL);
                            end
                        end
                    end
                    if (fx < 0 || fx > 2 * (GX - 1) || fy < 0 || fy > 2 * (GY - 1) ||
                        fz < 0 || fz > 2 * (GZ - 1))
                        r.status = vgss_pkg::ST_CLIP;
                end
            end
            default: ;
        endcase
        r.count = on_total[15:0];
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h", what, got, want);
        fail_cnt++;
    endtask

    task automatic drive_op(t_op_item it);
        in_if.opcode   <= it.op;
        in_if.first_x  <= it.fx;
        in_if.first_y  <= it.fy;
        in_if.first_z  <= it.fz;
        in_if.second_x <= it.sx;
        in_if.second_y <= it.sy;
        in_if.second_z <= it.sz;
    endtask

    // driver
    always @(posedge i_clk) begin
        int g;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            send_gap <= 0;
        end else if (in_if.valid && in_if.ready) begin
            res_expected.push_back(sculpt_predict(cur_op));
            g = draw_wait();
            if (g == 0 && op_pending.size() > 0) begin
                cur_op = op_pending.pop_front();
                drive_op(cur_op);
            end else begin
                in_if.valid <= 1'b0;
                send_gap <= g;
            end
        end else if (!in_if.valid) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (op_pending.size() > 0) begin
                cur_op = op_pending.pop_front();
                drive_op(cur_op);
                in_if.valid <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_voxel_res e;
        int h;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            recv_hold <= 0;
        end else if (out_if.valid && out_if.ready) begin
            if (res_expected.size() == 0) begin
                report("unexpected beat", out_if.filled_count, 0);
            end else begin
                e = res_expected.pop_front();
                if (out_if.voxel_on !== e.on) report("voxel_on", out_if.voxel_on, e.on);
                if (out_if.voxel_red !== e.color.red)
                    report("voxel_red", out_if.voxel_red, e.color.red);
                if (out_if.voxel_green !== e.color.green)
                    report("voxel_green", out_if.voxel_green, e.color.green);
                if (out_if.voxel_blue !== e.color.blue)
                    report("voxel_blue", out_if.voxel_blue, e.color.blue);
                if (out_if.voxel_alpha !== e.color.alpha)
                    report("voxel_alpha", out_if.voxel_alpha, e.color.alpha);
                if (out_if.filled_count !== e.count)
                    report("filled_count", out_if.filled_count, e.count);
                if (out_if.status !== e.status) report("status", out_if.status, e.status);
            end
            if (long_req != long_done) begin
                h = LONG_HOLD;
                long_done <= long_done + 1;
            end else begin
                h = draw_wait();
            end
            if (h == 0) begin
                out_if.ready <= 1'b1;
            end else begin
                out_if.ready <= 1'b0;
                recv_hold <= h;
            end
        end else if (!out_if.ready) begin
            if (recv_hold > 0) recv_hold <= recv_hold - 1;
            else out_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic t_op_item mk(logic [2:0] op, int fx, int fy, int fz,
                                    int sx, int sy, int sz);
        t_op_item it;
        it.op = op;
        it.fx = fx; it.fy = fy; it.fz = fz;
        it.sx = sx; it.sy = sy; it.sz = sz;
        return it;
    endfunction

    function automatic int rand_coord();
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, GX - 1);
        return int'($urandom_range(0, 191)) - 64;
    endfunction

    function automatic t_op_item rand_op();
        int r, lx, ly, lz;
        r = $urandom_range(0, 99);
        if (r < 20) return mk(vgss_pkg::OP_PUT_VOX, rand_coord(), rand_coord(), rand_coord(),
                              0, 0, 0);
        if (r < 30) return mk(vgss_pkg::OP_CUT_VOX, rand_coord(), rand_coord(), rand_coord(),
                              $urandom_range(0, 127), $urandom_range(0, 127),
                              $urandom_range(0, 127));
        if (r < 85 && r >= 55) begin
            // small boxes keep the sweep short
            lx = rand_coord(); ly = rand_coord(); lz = rand_coord();
            if (wide_box_budget > 0 && r < 58) begin
                wide_box_budget--;
                return mk(r[0] ? vgss_pkg::OP_PUT_BOX : vgss_pkg::OP_CUT_BOX, lx, ly, lz,
                          $urandom_range(0, 127), $urandom_range(0, 127),
                          $urandom_range(0, 127));
            end
            return mk(r < 72 ? vgss_pkg::OP_PUT_BOX : vgss_pkg::OP_CUT_BOX, lx, ly, lz,
                      (lx < 0 ? 0 : lx) + $urandom_range(0, 4),
                      (ly < 0 ? 0 : ly) + $urandom_range(0, 4),
                      (lz < 0 ? 0 : lz) + $urandom_range(0, 4));
        end
        if (r >= 85 && ell_budget > 0) begin
            ell_budget--;
            return mk(r < 93 ? vgss_pkg::OP_PUT_ELL : vgss_pkg::OP_CUT_ELL,
                      $urandom_range(0, 9) < 8 ? $urandom_range(0, 62) : rand_coord() * 2,
                      $urandom_range(0, 62), $urandom_range(0, 62),
                      $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 127),
                      $urandom_range(1, 40), $urandom_range(1, 40));
        end
        return mk(vgss_pkg::OP_READ, rand_coord(), rand_coord(), rand_coord(), 0, 0, 0);
    endfunction

    task automatic wait_idle();
        while (op_pending.size() > 0 || in_if.valid || res_expected.size() > 0)
            @(posedge i_clk);
    endtask

    task automatic set_paint(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
        logic [7:0] vals [4];
        vals = '{r, g, b, a};
        foreach (vals[i]) begin
            @(posedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= vgss_pkg::CFG_IDX_W'(i);
            i_cfg_data <= vals[i];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        paint = '{alpha: a, blue: b, green: g, red: r};
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.opcode = '0;
        in_if.first_x = '0;
        in_if.first_y = '0;
        in_if.first_z = '0;
        in_if.second_x = '0;
        in_if.second_y = '0;
        in_if.second_z = '0;
        out_if.ready = 1'b0;
        fail_cnt = 0;
        cycle_cnt = 0;
        no_idle = 0;
        long_req = 0;
        long_done = 0;
        ell_budget = 6;
        wide_box_budget = 3;
        on_total = 0;
        foreach (occ_map[i]) occ_map[i] = 1'b0;
        foreach (color_map[i]) color_map[i] = '0;
        paint = '{alpha: 8'd255, blue: 8'd0, green: 8'd0, red: 8'd0};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_paint(8'd255, 8'd0, 8'd128, 8'd255);
        // corners, clipping, empty and full boxes, ellipsoid corner cases
        op_pending.push_back(mk(vgss_pkg::OP_PUT_VOX, 0, 0, 0, 0, 0, 0));
        op_pending.push_back(mk(vgss_pkg::OP_PUT_VOX, 31, 31, 31, 127, 127, 127));
        op_pending.push_back(mk(vgss_pkg::OP_READ, 0, 0, 0, 0, 0, 0));
        op_pending.push_back(mk(vgss_pkg::OP_READ, 31, 31, 31, 0, 0, 0));
        op_pending.push_back(mk(vgss_pkg::OP_READ, -64, 5, 5, 0, 0, 0));
        op_pending.push_back(mk(vgss_pkg::OP_PUT_VOX, 127, 0, 0, 0, 0, 0));
        op_pending.push_back(mk(vgss_pkg::OP_CUT_VOX, 0, 0, -1, 0, 0, 0));
        op_pending.push_back(mk(vgss_pkg::OP_CUT_VOX, 31, 31, 31, 0, 0, 0));
        op_pending.push_back(mk(vgss_pkg::OP_READ, 31, 31, 31, 0, 0, 0));
        op_pending.push_back(mk(vgss_pkg::OP_PUT_BOX, 0, 0, 0, 32, 32, 32));
        op_pending.push_back(mk(vgss_pkg::OP_PUT_BOX, 5, 5, 5, 5, 9, 9));
        op_pending.push_back(mk(vgss_pkg::OP_CUT_BOX, -64, -1, -5, 127, 127, 127));
        op_pending.push_back(mk(vgss_pkg::OP_PUT_BOX, 30, 2, 2, 40, 4, 4));
        op_pending.push_back(mk(vgss_pkg::OP_PUT_ELL, 32, 32, 32, 10, 10, 10));
        op_pending.push_back(mk(vgss_pkg::OP_READ, 16, 16, 16, 0, 0, 0));
        op_pending.push_back(mk(vgss_pkg::OP_PUT_ELL, 10, 10, 10, 0, 5, 5));
        op_pending.push_back(mk(vgss_pkg::OP_PUT_ELL, -10, 70, 127, 40, 20, 30));
        op_pending.push_back(mk(vgss_pkg::OP_CUT_ELL, 0, 62, 0, 20, 127, 1));
        op_pending.push_back(mk(OP_UNUSED, -1, -1, -1, 127, 127, 127));
        op_pending.push_back(mk(vgss_pkg::OP_READ, 0, 31, 0, 0, 0, 0));
        wait_idle();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: set_paint(8'd0, 8'd0, 8'd0, 8'd0);
                1: set_paint(8'd255, 8'd255, 8'd255, 8'd255);
                default: set_paint($urandom_range(0, 255), $urandom_range(0, 255),
                                   $urandom_range(0, 255), $urandom_range(0, 255));
            endcase
            no_idle = (ph == 3);
            // receiver holds off while the sender keeps offering
            if (ph == 2) long_req++;
            for (int n = 0; n < 20; n++) op_pending.push_back(rand_op());
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        if (res_expected.size() > 0) report("results missing", res_expected.size(), 0);
        if (fail_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/vgss_pkg.sv
hw/rtl/vgss_in_if.sv
hw/rtl/vgss_out_if.sv
hw/rtl/vgss_mul.sv
hw/rtl/vgss_grid_mem.sv
hw/rtl/voxel_grid_shape_sculptor_core.sv
dv/tb_voxel_grid_shape_sculptor_core.sv
